[design/scale_space_extremum_3x3x3_macros.svh]
// assertion macros for the scale space extremum top level
`ifndef SCALE_SPACE_EXTREMUM_3X3X3_MACROS_SVH
`define SCALE_SPACE_EXTREMUM_3X3X3_MACROS_SVH
`ifndef ASSERT_OFF
`define SSE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("scale space extremum assertion failed");
`define SSE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("scale space extremum assertion failed");
`else
`define SSE_ASSERT(lbl, prop)
`define SSE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[design/sse_pkg.sv]
// constants and types of the scale space extremum block
package sse_pkg;

  localparam int NUM_SCALES   = 7;
  localparam int MAX_WIDTH    = 1024;
  localparam int SAMPLE_BITS  = 16;
  localparam int HEIGHT_LIMIT = 4096;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(HEIGHT_LIMIT);

  // register and field widths
  localparam int FW_W   = 11;
  localparam int FH_W   = 13;
  localparam int CFG_W  = 13;
  localparam int CX_W   = 10;
  localparam int CY_W   = 12;

  localparam int MIN_DIM      = 3;
  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_RESET = 480;

  // comparison slots per scale: three scales of a 3x3 window
  localparam int NBR = 27;

  typedef enum logic [0:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef logic signed [SAMPLE_BITS-1:0] samp_t;
  typedef logic [COL_W-1:0] col_t;
  typedef logic [ROW_W-1:0] row_t;
  typedef logic [NUM_SCALES-1:0] mask_t;

  // one line memory word: both stored lines of every scale, [s][0] newer, [s][1] older
  typedef logic [NUM_SCALES-1:0][1:0][SAMPLE_BITS-1:0] line_word_t;

endpackage

[design/sse_if.sv]
// valid/ready channel interfaces for pixel input and extremum result output
interface sse_in_if;
  import sse_pkg::*;

  logic  valid;
  logic  ready;
  samp_t resp_scale0;
  samp_t resp_scale1;
  samp_t resp_scale2;
  samp_t resp_scale3;
  samp_t resp_scale4;
  samp_t resp_scale5;
  samp_t resp_scale6;

  modport source (
    output valid, resp_scale0, resp_scale1, resp_scale2, resp_scale3,
           resp_scale4, resp_scale5, resp_scale6,
    input  ready
  );
  modport sink (
    input  valid, resp_scale0, resp_scale1, resp_scale2, resp_scale3,
           resp_scale4, resp_scale5, resp_scale6,
    output ready
  );
endinterface

interface sse_out_if;
  import sse_pkg::*;

  logic            valid;
  logic            ready;
  logic [CX_W-1:0] center_x;
  logic [CY_W-1:0] center_y;
  mask_t           max_mask;
  mask_t           min_mask;
  logic            frame_end;

  modport source (
    output valid, center_x, center_y, max_mask, min_mask, frame_end,
    input  ready
  );
  modport sink (
    input  valid, center_x, center_y, max_mask, min_mask, frame_end,
    output ready
  );
endinterface

[design/scale_space_extremum_3x3x3.sv]
// top level: 3x3x3 scale space extremum detector over a raster pixel stream
// a pixel passes stage 1, stage 2 and the output register, which presents its result
// throughput: one pixel per cycle unless output stalls; a line memory read and write a cycle
// border pixels (row or column 0 or 1) give no result and are dropped after the window stage
// reset clears the pipeline valids and the pixel counters and loads 640 x 480 geometry
// the line memory and the windows are not cleared; border rows never use their stale data
`include "scale_space_extremum_3x3x3_macros.svh"

module scale_space_extremum_3x3x3 (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [0:0]                cfg_idx_i,
  input  logic [sse_pkg::CFG_W-1:0] cfg_data_i,
  sse_in_if.sink                    in_i,
  sse_out_if.source                 out_o
);
  import sse_pkg::*;

  // configuration
  logic [FW_W-1:0] frame_width_q;
  logic [FH_W-1:0] frame_height_q;
  logic [FW_W-1:0] fw_lim;
  logic [FH_W-1:0] fh_lim;
  col_t            w_last;
  row_t            h_last;

  // pixel counters
  col_t col_count_q, col_count_d;
  row_t row_count_q, row_count_d;
  col_t col_eff;
  row_t row_eff;

  // handshake and stage control
  logic in_acc;
  logic s1_free, s1_leave;
  logic s2_free, s2_go;

  // stage 1: pixel plus line memory read data
  logic            s1_valid_q;
  logic            s1_emit_q;
  logic            s1_fend_q;
  col_t            s1_col_q;
  logic [CX_W-1:0] s1_cx_q;
  logic [CY_W-1:0] s1_cy_q;
  samp_t           s1_new_q [NUM_SCALES];
  samp_t           in_samp  [NUM_SCALES];
  line_word_t      rd_q;
  line_word_t      wr_data;
  line_word_t      line_mem_q [MAX_WIDTH];

  // 3x3 window per scale, and the window once the stage 1 pixel has shifted in
  samp_t win_q  [NUM_SCALES][3][3];
  samp_t win_nx [NUM_SCALES][3][3];

  // stage 2: comparison bits
  logic                            s2_valid_q;
  logic                            s2_fend_q;
  logic [CX_W-1:0]                 s2_cx_q;
  logic [CY_W-1:0]                 s2_cy_q;
  logic [NUM_SCALES-1:0][NBR-1:0]  gt_d, lt_d;
  logic [NUM_SCALES-1:0][NBR-1:0]  s2_gt_q, s2_lt_q;

  // output register
  logic            out_valid_q;
  logic [CX_W-1:0] out_cx_q;
  logic [CY_W-1:0] out_cy_q;
  mask_t           out_max_q, out_min_q;
  mask_t           max_d, min_d;
  logic            out_fend_q;

  // ---------------------------------------------------------------
  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FW_W'(WIDTH_RESET);
      frame_height_q <= FH_W'(HEIGHT_RESET);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[FW_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[FH_W-1:0];
      endcase
    end
  end

  // saturate geometry into the supported range
  always_comb begin
    if (frame_width_q < FW_W'(MIN_DIM)) begin
      fw_lim = FW_W'(MIN_DIM);
    end else if (frame_width_q > FW_W'(MAX_WIDTH)) begin
      fw_lim = FW_W'(MAX_WIDTH);
    end else begin
      fw_lim = frame_width_q;
    end
    if (frame_height_q < FH_W'(MIN_DIM)) begin
      fh_lim = FH_W'(MIN_DIM);
    end else if (frame_height_q > FH_W'(HEIGHT_LIMIT)) begin
      fh_lim = FH_W'(HEIGHT_LIMIT);
    end else begin
      fh_lim = frame_height_q;
    end
  end

  assign w_last = COL_W'(fw_lim - FW_W'(1));
  assign h_last = ROW_W'(fh_lim - FH_W'(1));

  // ---------------------------------------------------------------
  // stage control: each stage moves when the next one is free or moving
  assign s2_go    = !out_valid_q || out_o.ready;
  assign s2_free  = !s2_valid_q || s2_go;
  // border pixels only update the window, so they never wait on stage 2
  assign s1_leave = s1_valid_q && (!s1_emit_q || s2_free);
  assign s1_free  = !s1_valid_q || s1_leave;
  assign in_i.ready = s1_free;
  assign in_acc     = in_i.valid && s1_free;

  // ---------------------------------------------------------------
  // pixel position; a counter past a shrunken geometry wraps at once
  assign col_eff = (col_count_q > w_last) ? w_last : col_count_q;
  assign row_eff = (row_count_q > h_last) ? h_last : row_count_q;

  always_comb begin
    col_count_d = col_count_q;
    row_count_d = row_count_q;
    if (in_acc) begin
      if (col_eff >= w_last) begin
        col_count_d = '0;
        row_count_d = (row_eff >= h_last) ? '0 : row_eff + ROW_W'(1);
      end else begin
        col_count_d = col_eff + COL_W'(1);
        row_count_d = row_eff;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_count_q <= '0;
      row_count_q <= '0;
    end else begin
      col_count_q <= col_count_d;
      row_count_q <= row_count_d;
    end
  end

  // ---------------------------------------------------------------
  // stage 1: capture the pixel and read both stored lines at its column
  assign in_samp[0] = in_i.resp_scale0;
  assign in_samp[1] = in_i.resp_scale1;
  assign in_samp[2] = in_i.resp_scale2;
  assign in_samp[3] = in_i.resp_scale3;
  assign in_samp[4] = in_i.resp_scale4;
  assign in_samp[5] = in_i.resp_scale5;
  assign in_samp[6] = in_i.resp_scale6;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_free) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_emit_q <= (col_eff >= COL_W'(2)) && (row_eff >= ROW_W'(2));
      s1_fend_q <= (col_eff == w_last) && (row_eff == h_last);
      s1_col_q  <= col_eff;
      s1_cx_q   <= CX_W'(col_eff - COL_W'(1));
      s1_cy_q   <= CY_W'(row_eff - ROW_W'(1));
      s1_new_q  <= in_samp;
    end
  end

  // line memory: newer line moves to the older slot, the new pixel takes the newer slot
  always_comb begin
    for (int s = 0; s < NUM_SCALES; s++) begin
      wr_data[s][1] = rd_q[s][0];
      wr_data[s][0] = s1_new_q[s];
    end
  end

  // at fixed geometry consecutive pixels differ in column, so read and write never collide
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_q <= line_mem_q[col_eff];
    end
    if (s1_leave) begin
      line_mem_q[s1_col_q] <= wr_data;
    end
  end

  // window shift: oldest column drops out, the new column is older line, newer line, pixel
  always_comb begin
    for (int s = 0; s < NUM_SCALES; s++) begin
      for (int r = 0; r < 3; r++) begin
        win_nx[s][r][0] = win_q[s][r][1];
        win_nx[s][r][1] = win_q[s][r][2];
      end
      win_nx[s][0][2] = samp_t'(rd_q[s][1]);
      win_nx[s][1][2] = samp_t'(rd_q[s][0]);
      win_nx[s][2][2] = s1_new_q[s];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_leave) begin
      win_q <= win_nx;
    end
  end

  // ---------------------------------------------------------------
  // stage 2: every center against its 26 neighbors; the self slot tests the sign,
  // slots of a missing neighbor scale pass
  for (genvar s = 0; s < NUM_SCALES; s++) begin : g_scale
    for (genvar d = 0; d < 3; d++) begin : g_dscale
      for (genvar r = 0; r < 3; r++) begin : g_row
        for (genvar k = 0; k < 3; k++) begin : g_col
          if ((s + d - 1 < 0) || (s + d - 1 >= NUM_SCALES)) begin : g_none
            assign gt_d[s][d*9 + r*3 + k] = 1'b1;
            assign lt_d[s][d*9 + r*3 + k] = 1'b1;
          end else if (d == 1 && r == 1 && k == 1) begin : g_sign
            assign gt_d[s][d*9 + r*3 + k] = win_nx[s][1][1] > 0;
            assign lt_d[s][d*9 + r*3 + k] = win_nx[s][1][1] < 0;
          end else begin : g_cmp
            assign gt_d[s][d*9 + r*3 + k] = win_nx[s][1][1] > win_nx[s + d - 1][r][k];
            assign lt_d[s][d*9 + r*3 + k] = win_nx[s][1][1] < win_nx[s + d - 1][r][k];
          end
        end
      end
    end
  end

  // comparisons see the window with the stage 1 pixel already shifted in
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_free) begin
      s2_valid_q <= s1_leave && s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_leave && s1_emit_q) begin
      s2_gt_q   <= gt_d;
      s2_lt_q   <= lt_d;
      s2_cx_q   <= s1_cx_q;
      s2_cy_q   <= s1_cy_q;
      s2_fend_q <= s1_fend_q;
    end
  end

  // ---------------------------------------------------------------
  // output stage: a scale is an extremum when all of its slots agree
  always_comb begin
    for (int s = 0; s < NUM_SCALES; s++) begin
      max_d[s] = &s2_gt_q[s];
      min_d[s] = &s2_lt_q[s];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_go) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_go && s2_valid_q) begin
      out_cx_q   <= s2_cx_q;
      out_cy_q   <= s2_cy_q;
      out_max_q  <= max_d;
      out_min_q  <= min_d;
      out_fend_q <= s2_fend_q;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.center_x  = out_cx_q;
  assign out_o.center_y  = out_cy_q;
  assign out_o.max_mask  = out_max_q;
  assign out_o.min_mask  = out_min_q;
  assign out_o.frame_end = out_fend_q;

  // ---------------------------------------------------------------
  // a reported center is never on the first row or column
  `SSE_ASSERT(a_out_interior, out_valid_q |-> (out_cx_q != '0 && out_cy_q != '0))
  // a center cannot be both a maximum and a minimum at one scale
  `SSE_ASSERT(a_mask_excl, out_valid_q |-> ((out_max_q & out_min_q) == '0))
  // a border pixel in stage 1 never holds off the input
  `SSE_ASSERT(a_border_free, (s1_valid_q && !s1_emit_q) |-> in_i.ready)
  // a stalled comparison result stays in stage 2
  `SSE_ASSERT_NEXT(a_s2_hold, s2_valid_q && !s2_go, s2_valid_q)

endmodule
